// File: design/rv32_pkg.sv
`default_nettype none
package rv32_pkg;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] instruction_address;
    logic [31:0] next_address;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [2:0]  mem_bytes;
  } out_item_t;

  localparam logic [2:0] ST_RETIRED = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_STORE   = 3'd2;
  localparam logic [2:0] ST_EBREAK  = 3'd3;
  localparam logic [2:0] ST_UNIMPL  = 3'd4;
  localparam logic [2:0] ST_INVALID = 3'd5;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0f;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  localparam logic [4:0] REG_A0 = 5'd10;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic        want_rem;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: design/rv32im_instruction_execute_top.sv
`default_nettype none
// RV32IM execute unit: each transfer on in_ carries either a fetched instruction
// word (executed at the current pc) or the data for the outstanding load, and
// yields exactly one result on out_. The register file is a synchronous memory
// read in the cycle after the item is taken (S_READ); a plain instruction then
// passes S_EXEC and S_DONE, a multiply also S_MUL (a single 33x33 product, then
// a register), and a divide or remainder waits in S_DIV (one quotient bit per
// cycle; a zero divisor or signed overflow skips the iteration). One item is in
// flight at a time; in_ready returns once the result has been transferred on
// out_. The reset vector set via cfg_we/cfg_wdata only takes effect at next reset.
module rv32im_instruction_execute_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rv32_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rv32_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE} state_t;

  state_t              state_r;
  rv32_pkg::in_item_t  item_r;
  rv32_pkg::out_item_t res_r, res_nxt;
  logic [31:0] rvec_r;
  logic [31:0] pc_r, pc_nxt;
  logic [4:0]  pld_r, pld_nxt;
  logic [2:0]  pkind_r, pkind_nxt;
  logic        we_r, we_nxt;
  logic [4:0]  wa_r, wa_nxt;
  logic [31:0] wd_r, wd_nxt;
  logic        is_mul_nxt, is_div_nxt;
  logic [1:0]  mul_kind_r;
  logic [65:0] prod_r;
  logic        pending_r;

  logic [31:0] ra, rb;
  logic [4:0]  addr_a, addr_b;
  rv32_pkg::div_req_t dreq;
  rv32_pkg::div_rsp_t drsp;

  logic [31:0] w;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j, pc4, v, lv, alu_b;
  logic        bad, take, wr;
  logic [32:0] ma, mb;

  assign w = item_r.instruction;
  assign opc = w[6:0];
  assign rd  = w[11:7];
  assign f3  = w[14:12];
  assign f7  = w[31:25];
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_u = {w[31:12], 12'd0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign pc4 = pc_r + 32'd4;

  // ebreak needs a0 on port a; otherwise rs1/rs2 of the held word
  assign addr_a = (w == rv32_pkg::W_EBREAK) ? rv32_pkg::REG_A0 : w[19:15];
  assign addr_b = w[24:20];

  rv32_regfile u_rf (
    .clk, .rst_n,
    .rd_addr_a(addr_a), .rd_addr_b(addr_b),
    .rd_data_a(ra), .rd_data_b(rb),
    .wr_en(we_r), .wr_addr(wa_r), .wr_data(wd_r)
  );

  rv32_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  always_comb begin
    v = '0; bad = 1'b0; take = 1'b0; wr = 1'b0;
    alu_b = (opc == rv32_pkg::OP_REG) ? rb : imm_i;
    is_mul_nxt = 1'b0; is_div_nxt = 1'b0;
    res_nxt = '0;
    res_nxt.instruction_address = pc_r;
    res_nxt.next_address = pc4;
    pc_nxt = pc4; pld_nxt = pld_r; pkind_nxt = pkind_r;
    // load response data
    unique case (pkind_r[1:0])
      2'd0:    lv = pkind_r[2] ? {24'd0, item_r.load_value[7:0]}
                               : {{24{item_r.load_value[7]}}, item_r.load_value[7:0]};
      2'd1:    lv = pkind_r[2] ? {16'd0, item_r.load_value[15:0]}
                               : {{16{item_r.load_value[15]}}, item_r.load_value[15:0]};
      default: lv = item_r.load_value;
    endcase
    if (item_r.operation) begin
      res_nxt.next_address = pc_r;
      res_nxt.mem_data = lv;
      res_nxt.mem_bytes = (pkind_r[1:0] == 2'd0) ? 3'd1 : (pkind_r[1:0] == 2'd1) ? 3'd2 : 3'd4;
      pc_nxt = pc_r; pld_nxt = '0; pkind_nxt = '0;
    end else begin
      unique case (opc)
        rv32_pkg::OP_LUI:   begin wr = 1'b1; v = imm_u; end
        rv32_pkg::OP_AUIPC: begin wr = 1'b1; v = pc_r + imm_u; end
        rv32_pkg::OP_JAL:   begin wr = 1'b1; v = pc4; pc_nxt = pc_r + imm_j; end
        rv32_pkg::OP_JALR: begin
          if (f3 != 3'd0) bad = 1'b1;
          else begin wr = 1'b1; v = pc4; pc_nxt = (ra + imm_i) & ~32'd1; end
        end
        rv32_pkg::OP_BRANCH: begin
          unique case (f3)
            3'd0: take = ra == rb;
            3'd1: take = ra != rb;
            3'd4: take = $signed(ra) < $signed(rb);
            3'd5: take = $signed(ra) >= $signed(rb);
            3'd6: take = ra < rb;
            3'd7: take = ra >= rb;
            default: bad = 1'b1;
          endcase
          if (take) pc_nxt = pc_r + imm_b;
        end
        rv32_pkg::OP_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) bad = 1'b1;
          else begin
            res_nxt.status = rv32_pkg::ST_LOAD;
            res_nxt.mem_address = ra + imm_i;
            res_nxt.mem_bytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
            pld_nxt = rd; pkind_nxt = f3;
          end
        end
        rv32_pkg::OP_STORE: begin
          if (f3 > 3'd2) bad = 1'b1;
          else begin
            res_nxt.status = rv32_pkg::ST_STORE;
            res_nxt.mem_address = ra + imm_s;
            res_nxt.mem_data = rb;
            res_nxt.mem_bytes = (f3 == 3'd0) ? 3'd1 : (f3 == 3'd1) ? 3'd2 : 3'd4;
          end
        end
        rv32_pkg::OP_IMM, rv32_pkg::OP_REG: begin
          wr = 1'b1;
          if (opc == rv32_pkg::OP_REG && f7 == rv32_pkg::F7_MUL) begin
            if (f3[2]) is_div_nxt = 1'b1; else is_mul_nxt = 1'b1;
          end else if (opc == rv32_pkg::OP_REG && f7 != rv32_pkg::F7_BASE
                       && !(f7 == rv32_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
            bad = 1'b1;
          end else begin
            unique case (f3)
              3'd0: v = (opc == rv32_pkg::OP_REG && f7 == rv32_pkg::F7_ALT) ? ra - rb
                                                                             : ra + alu_b;
              3'd1: begin
                if (f7 != rv32_pkg::F7_BASE) bad = 1'b1;
                v = ra << alu_b[4:0];
              end
              3'd2: v = {31'd0, $signed(ra) < $signed(alu_b)};
              3'd3: v = {31'd0, ra < alu_b};
              3'd4: v = ra ^ alu_b;
              3'd5: begin
                if (f7 == rv32_pkg::F7_BASE) v = ra >> alu_b[4:0];
                else if (f7 == rv32_pkg::F7_ALT) v = 32'($signed(ra) >>> alu_b[4:0]);
                else bad = 1'b1;
              end
              3'd6: v = ra | alu_b;
              3'd7: v = ra & alu_b;
              default: v = '0;
            endcase
          end
        end
        rv32_pkg::OP_FENCE: begin
          if (f3 == 3'd0) res_nxt.status = rv32_pkg::ST_UNIMPL; else bad = 1'b1;
        end
        rv32_pkg::OP_SYSTEM: begin
          if (w == rv32_pkg::W_ECALL) res_nxt.status = rv32_pkg::ST_UNIMPL;
          else if (w == rv32_pkg::W_EBREAK) begin
            res_nxt.status = rv32_pkg::ST_EBREAK;
            res_nxt.mem_data = ra;
          end else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        res_nxt = '0;
        res_nxt.status = rv32_pkg::ST_INVALID;
        res_nxt.instruction_address = pc_r;
        pc_nxt = pc4; wr = 1'b0; is_mul_nxt = 1'b0; is_div_nxt = 1'b0;
        pld_nxt = pld_r; pkind_nxt = pkind_r;
      end
      res_nxt.next_address = pc_nxt;
    end
    we_nxt = item_r.operation ? (pld_r != 5'd0) : (wr && rd != 5'd0);
    wa_nxt = item_r.operation ? pld_r : rd;
    wd_nxt = item_r.operation ? lv : v;
    // multiply operands: 33-bit signed extension per mulh variant
    ma = {(f3 == 3'd1 || f3 == 3'd2) && ra[31], ra};
    mb = {(f3 == 3'd1) && rb[31], rb};
    dreq.start = (state_r == S_EXEC) && is_div_nxt;
    dreq.is_signed = !f3[0];
    dreq.want_rem = f3[1];
    dreq.a = ra;
    dreq.b = rb;
  end

  assign in_ready = (state_r == S_IDLE) && !pending_r;
  assign out_valid = pending_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pending_r <= 1'b0;
      we_r      <= 1'b0;
      pc_r      <= rvec_r;
      pld_r     <= '0;
      pkind_r   <= '0;
      rvec_r    <= 32'h8000_0000;
    end else begin
      if (cfg_we) rvec_r <= cfg_wdata;
      if (state_r == S_DONE) pending_r <= 1'b1;
      else if (pending_r && out_ready) pending_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          we_r <= 1'b0;
          if (in_valid && in_ready) begin
            item_r  <= in_data;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          we_r    <= 1'b0;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          res_r   <= res_nxt;
          pc_r    <= pc_nxt;
          pld_r   <= pld_nxt;
          pkind_r <= pkind_nxt;
          wa_r    <= wa_nxt;
          wd_r    <= wd_nxt;
          prod_r  <= 66'($signed(ma) * $signed(mb));
          mul_kind_r <= f3[1:0];
          we_r    <= we_nxt && !is_mul_nxt && !is_div_nxt;
          if (is_mul_nxt) state_r <= S_MUL;
          else if (is_div_nxt) state_r <= S_DIV;
          else state_r <= S_DONE;
        end
        S_MUL: begin
          we_r    <= wa_r != 5'd0;
          wd_r    <= (mul_kind_r == 2'd0) ? prod_r[31:0] : prod_r[63:32];
          state_r <= S_DONE;
        end
        S_DIV: begin
          we_r <= drsp.done && wa_r != 5'd0;
          if (drsp.done) begin
            wd_r    <= drsp.result;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          we_r    <= 1'b0;
          state_r <= S_IDLE;
        end
        default: begin
          we_r    <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/rv32_regfile.sv
`default_nettype none
module rv32_regfile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  rd_addr_a,
  input  wire logic [4:0]  rd_addr_b,
  output logic      [31:0] rd_data_a,
  output logic      [31:0] rd_data_b,
  input  wire logic        wr_en,
  input  wire logic [4:0]  wr_addr,
  input  wire logic [31:0] wr_data
);

  logic [31:0] mem_a [32];
  logic [31:0] mem_b [32];
  logic [31:0] valid_r;
  logic [31:0] raw_a_r;
  logic [31:0] raw_b_r;
  logic        ok_a_r;
  logic        ok_b_r;

  // two copies give two read ports; valid bits emulate the zero reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    raw_a_r <= mem_a[rd_addr_a];
    raw_b_r <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ok_a_r  <= 1'b0;
      ok_b_r  <= 1'b0;
    end else begin
      if (wr_en && wr_addr != 5'd0) valid_r[wr_addr] <= 1'b1;
      ok_a_r <= valid_r[rd_addr_a] && rd_addr_a != 5'd0;
      ok_b_r <= valid_r[rd_addr_b] && rd_addr_b != 5'd0;
    end
  end

  assign rd_data_a = ok_a_r ? raw_a_r : '0;
  assign rd_data_b = ok_b_r ? raw_b_r : '0;

endmodule
`default_nettype wire

// File: design/rv32_divider.sv
`default_nettype none
module rv32_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rv32_pkg::div_req_t req,
  output rv32_pkg::div_rsp_t      rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic        rem_sel_r, rem_sel_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    mag_a = (req.is_signed && req.a[31]) ? 32'd0 - req.a : req.a;
    mag_b = (req.is_signed && req.b[31]) ? 32'd0 - req.b : req.b;
    shifted = {rem_r, quo_r[31]};
    trial   = shifted - {1'b0, div_r};
    quo_nxt = quo_r; rem_nxt = rem_r; div_nxt = div_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r;
    rem_sel_nxt = rem_sel_r; done_nxt = 1'b0; res_nxt = res_r;
    if (req.start) begin
      if (req.b == 32'd0) begin
        done_nxt = 1'b1;
        res_nxt  = req.want_rem ? req.a : 32'hffff_ffff;
      end else if (req.is_signed && req.a == 32'h8000_0000 && req.b == 32'hffff_ffff) begin
        done_nxt = 1'b1;
        res_nxt  = req.want_rem ? 32'd0 : req.a;
      end else begin
        busy_nxt = 1'b1; cnt_nxt = 6'd32; quo_nxt = mag_a; rem_nxt = '0; div_nxt = mag_b;
        neg_q_nxt = req.is_signed && (req.a[31] ^ req.b[31]);
        neg_r_nxt = req.is_signed && req.a[31];
        rem_sel_nxt = req.want_rem;
      end
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (rem_sel_r) res_nxt = neg_r_r ? 32'd0 - rem_r : rem_r;
        else           res_nxt = neg_q_r ? 32'd0 - quo_r : quo_r;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = shifted[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt; rem_r <= rem_nxt; div_r <= div_nxt;
    neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt; rem_sel_r <= rem_sel_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
`default_nettype wire
